// ===== design/wts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the window token scheduler.
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int NUM_SENDERS = 32;
	localparam int SENDER_W    = $clog2(NUM_SENDERS);
	localparam int COUNT_W     = 6;
	localparam int FREE_W      = 6;
	localparam int BYTES_W     = 32;
	localparam int PKT_W       = 16;
	localparam int WIN_W       = 16;
	localparam int SHIFT_W     = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// item kinds
	localparam logic KIND_BURST = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	// register reset values
	localparam logic [COUNT_W-1:0] RST_ACTIVE_SENDERS = 6'd32;
	localparam logic [FREE_W-1:0]  RST_MAX_TOKENS     = 6'd20;
	localparam logic [BYTES_W-1:0] RST_BYTES_PER_SND  = 32'd1448;
	localparam logic [BYTES_W-1:0] RST_GRANT_WINDOW   = 32'd65535;
	localparam logic [SHIFT_W-1:0] RST_WINDOW_SHIFT   = 4'd0;
	localparam logic [WIN_W-1:0]   RST_MIN_WINDOW     = 16'd2048;
	localparam logic [WIN_W-1:0]   RST_MAX_WINDOW     = 16'd65535;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SENDERS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRANT_WINDOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SHIFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW     = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BURST,
		ST_UPDATE,
		ST_STATUS,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE,
		ST_GRANT
	} state_t;

	typedef enum logic [1:0] {
		EMIT_STATUS,
		EMIT_BURST,
		EMIT_DONE,
		EMIT_GRANT
	} emit_sel_t;

	typedef struct packed {
		logic      capture;
		logic      clear_burst;
		logic      update;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      scan_rd;
		logic      emit;
		emit_sel_t emit_sel;
	} wts_cmd_t;

	typedef struct packed {
		logic is_burst;
		logic in_range;
		logic upd_done;
		logic burst_last;
		logic scan_last;
		logic grant_more;
		logic grant_last;
		logic out_free;
	} wts_status_t;

endpackage

// ===== design/window_token_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_token_scheduler_core
// Token scheduler for receive windows of a burst of senders.
//
//   channel  handshake            payload
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_ready    kind, sender_index, byte_count
//   out      out_valid/out_ready  target_sender, window_value, window_valid,
//                                 sender_done, burst_done, last
//
// one item at a time; burst start: DISPATCH, then BURST emits one result per
// active sender; data item with no completion: DISPATCH, UPDATE, STATUS, or
// DISPATCH, STATUS when the sender is outside the burst; completing item:
// UPDATE, 32-entry SCAN of the byte count memory (one read port), SCAN_END,
// DONE, then one GRANT result per granted token; reset loads register
// defaults and clears all flags; no clearing pass; results leave through one
// output register; a stalled output holds the controller in place
// ----------------------------------------------------------------------------
module window_token_scheduler_core
	import wts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [SENDER_W-1:0]   sender_index,
	input  logic [PKT_W-1:0]      byte_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SENDER_W-1:0]   target_sender,
	output logic [WIN_W-1:0]      window_value,
	output logic                  window_valid,
	output logic                  sender_done,
	output logic                  burst_done,
	output logic                  last
);

	wts_cmd_t    cmd;
	wts_status_t status;

	wts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	wts_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.sender_index  (sender_index),
		.byte_count    (byte_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.target_sender (target_sender),
		.window_value  (window_value),
		.window_valid  (window_valid),
		.sender_done   (sender_done),
		.burst_done    (burst_done),
		.last          (last),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

// ===== design/wts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_ctrl
// Controller of the window token scheduler: sequences burst start, byte
// update, eligibility scan and token grants.
// ----------------------------------------------------------------------------
module wts_ctrl
	import wts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  wts_status_t status,
	output wts_cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.is_burst) begin
					state_nxt = ST_BURST;
				end else if (!status.in_range) begin
					state_nxt = ST_STATUS;
				end else begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_BURST: begin
				if (status.out_free && status.burst_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_UPDATE: begin
				state_nxt = status.upd_done ? ST_SCAN : ST_STATUS;
			end
			ST_STATUS: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_nxt = status.grant_more ? ST_GRANT : ST_IDLE;
				end
			end
			ST_GRANT: begin
				if (status.out_free && status.grant_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.emit_sel = EMIT_STATUS;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				cmd.clear_burst = status.is_burst;
				cmd.cnt_clr     = 1'b1;
			end
			ST_BURST: begin
				cmd.emit     = status.out_free;
				cmd.cnt_inc  = status.out_free;
				cmd.emit_sel = EMIT_BURST;
			end
			ST_UPDATE: begin
				cmd.update  = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			ST_STATUS: begin
				cmd.emit     = status.out_free;
				cmd.emit_sel = EMIT_STATUS;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_SCAN_END: begin
				cmd.cnt_clr = 1'b1;
			end
			ST_DONE: begin
				cmd.emit     = status.out_free;
				cmd.emit_sel = EMIT_DONE;
			end
			ST_GRANT: begin
				cmd.emit     = status.out_free;
				cmd.emit_sel = EMIT_GRANT;
			end
			default: begin
				cmd.emit_sel = EMIT_STATUS;
			end
		endcase
	end

endmodule

// ===== design/wts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_datapath
// Datapath of the window token scheduler: registers, byte count memory,
// sender flags, token pool, grant pick and result register.
// ----------------------------------------------------------------------------
module wts_datapath
	import wts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input item
	input  logic                  kind,
	input  logic [SENDER_W-1:0]   sender_index,
	input  logic [PKT_W-1:0]      byte_count,
	// result item
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SENDER_W-1:0]   target_sender,
	output logic [WIN_W-1:0]      window_value,
	output logic                  window_valid,
	output logic                  sender_done,
	output logic                  burst_done,
	output logic                  last,
	// controller
	input  wts_cmd_t              cmd,
	output wts_status_t           status
);

	// configuration registers
	logic [COUNT_W-1:0] active_senders_q;
	logic [FREE_W-1:0]  max_tokens_q;
	logic [BYTES_W-1:0] bytes_per_sender_q;
	logic [BYTES_W-1:0] grant_window_q;
	logic [SHIFT_W-1:0] window_shift_q;
	logic [WIN_W-1:0]   min_window_q;
	logic [WIN_W-1:0]   max_window_q;

	// captured item
	logic                kind_q;
	logic [SENDER_W-1:0] idx_q;
	logic [PKT_W-1:0]    bytes_q;

	// sender state
	logic [BYTES_W-1:0]     recv_mem_q [NUM_SENDERS];
	logic [NUM_SENDERS-1:0] ent_valid_q;
	logic [NUM_SENDERS-1:0] finished_q;
	logic [NUM_SENDERS-1:0] holds_q;
	logic [NUM_SENDERS-1:0] reached_q;
	logic [FREE_W-1:0]      free_q;
	logic [SENDER_W-1:0]    cnt_q;

	// memory read pipeline
	logic [SENDER_W-1:0] rd_addr;
	logic [BYTES_W-1:0]  rd_data_s1;
	logic                rd_hit_s1;
	logic                scan_en_s1;
	logic [SENDER_W-1:0] scan_tag_s1;
	logic [BYTES_W-1:0]  rd_value;

	// result register
	logic                out_valid_q;
	logic [SENDER_W-1:0] target_q;
	logic [WIN_W-1:0]    window_q;
	logic                window_valid_q;
	logic                sender_done_q;
	logic                burst_done_q;
	logic                last_q;

	// combinational
	logic [COUNT_W-1:0]     n_act;
	logic [NUM_SENDERS-1:0] mask_n;
	logic [BYTES_W-1:0]     win_floor;
	logic [BYTES_W-1:0]     win_shifted;
	logic [WIN_W-1:0]       scaled;
	logic [BYTES_W:0]       sum_wide;
	logic [BYTES_W-1:0]     sum_sat;
	logic                   upd_done;
	logic [NUM_SENDERS-1:0] elig;
	logic [NUM_SENDERS-1:0] pick_oh;
	logic [SENDER_W-1:0]    pick_idx;
	logic                   burst_grant;
	logic                   all_finished;
	logic                   grant_more;
	logic                   grant_last;
	logic                   burst_last;
	logic                   out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_senders_q   <= RST_ACTIVE_SENDERS;
			max_tokens_q       <= RST_MAX_TOKENS;
			bytes_per_sender_q <= RST_BYTES_PER_SND;
			grant_window_q     <= RST_GRANT_WINDOW;
			window_shift_q     <= RST_WINDOW_SHIFT;
			min_window_q       <= RST_MIN_WINDOW;
			max_window_q       <= RST_MAX_WINDOW;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ACTIVE_SENDERS: active_senders_q   <= cfg_data[COUNT_W-1:0];
				CFG_MAX_TOKENS:     max_tokens_q       <= cfg_data[FREE_W-1:0];
				CFG_BYTES_PER_SND:  bytes_per_sender_q <= cfg_data[BYTES_W-1:0];
				CFG_GRANT_WINDOW:   grant_window_q     <= cfg_data[BYTES_W-1:0];
				CFG_WINDOW_SHIFT:   window_shift_q     <= cfg_data[SHIFT_W-1:0];
				CFG_MIN_WINDOW:     min_window_q       <= cfg_data[WIN_W-1:0];
				CFG_MAX_WINDOW:     max_window_q       <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// active sender count, clamped to one..NUM_SENDERS
	always_comb begin
		if (active_senders_q == '0) begin
			n_act = COUNT_W'(1);
		end else if (active_senders_q > COUNT_W'(NUM_SENDERS)) begin
			n_act = COUNT_W'(NUM_SENDERS);
		end else begin
			n_act = active_senders_q;
		end
		for (int i = 0; i < NUM_SENDERS; i++) begin
			mask_n[i] = COUNT_W'(i) < n_act;
		end
	end

	// granted window: floor, scale, saturate
	always_comb begin
		win_floor   = (grant_window_q < {16'b0, min_window_q}) ? {16'b0, min_window_q}
		                                                       : grant_window_q;
		win_shifted = win_floor >> window_shift_q;
		scaled      = (win_shifted > {16'b0, max_window_q}) ? max_window_q
		                                                    : win_shifted[WIN_W-1:0];
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			idx_q   <= sender_index;
			bytes_q <= byte_count;
		end
	end

	// byte count memory, registered read
	assign rd_addr = cmd.scan_rd ? cnt_q : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			recv_mem_q[idx_q] <= sum_sat;
		end
		rd_data_s1  <= recv_mem_q[rd_addr];
		rd_hit_s1   <= ent_valid_q[rd_addr];
		scan_tag_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_s1 <= 1'b0;
		end else begin
			scan_en_s1 <= cmd.scan_rd;
		end
	end

	// entries not written since burst start read as zero
	assign rd_value = rd_hit_s1 ? rd_data_s1 : '0;

	always_comb begin
		sum_wide = {1'b0, rd_value} + {{(BYTES_W+1-PKT_W){1'b0}}, bytes_q};
		sum_sat  = sum_wide[BYTES_W] ? '1 : sum_wide[BYTES_W-1:0];
		upd_done = !finished_q[idx_q] && (sum_sat >= bytes_per_sender_q);
	end

	// senders that may still get a token
	assign elig    = mask_n & ~finished_q & ~holds_q & ~reached_q;
	assign pick_oh = elig & (~elig + {{(NUM_SENDERS-1){1'b0}}, 1'b1});

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < NUM_SENDERS; i++) begin
			if (pick_oh[i]) begin
				pick_idx = SENDER_W'(i);
			end
		end
	end

	assign burst_grant  = (free_q != '0) && (bytes_per_sender_q != '0);
	assign all_finished = &(finished_q | ~mask_n);
	assign grant_more   = (free_q != '0) && (elig != '0);
	assign grant_last   = (free_q == FREE_W'(1)) || ((elig & ~pick_oh) == '0);
	assign burst_last   = ({1'b0, cnt_q} == (n_act - COUNT_W'(1)));
	assign out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + SENDER_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
		end else if (scan_en_s1) begin
			reached_q[scan_tag_s1] <= rd_value >= bytes_per_sender_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q  <= '0;
			holds_q     <= '0;
			ent_valid_q <= '0;
			free_q      <= RST_MAX_TOKENS;
		end else begin
			if (cmd.clear_burst) begin
				finished_q  <= '0;
				holds_q     <= '0;
				ent_valid_q <= '0;
				free_q      <= max_tokens_q;
			end
			if (cmd.update) begin
				ent_valid_q[idx_q] <= 1'b1;
				if (upd_done) begin
					finished_q[idx_q] <= 1'b1;
					// token goes back to the pool only if it was held
					if (holds_q[idx_q]) begin
						holds_q[idx_q] <= 1'b0;
						free_q         <= free_q + FREE_W'(1);
					end
				end
			end
			if (cmd.emit && cmd.emit_sel == EMIT_BURST && burst_grant) begin
				holds_q[cnt_q] <= 1'b1;
				free_q         <= free_q - FREE_W'(1);
			end
			if (cmd.emit && cmd.emit_sel == EMIT_GRANT) begin
				holds_q[pick_idx] <= 1'b1;
				free_q            <= free_q - FREE_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			burst_done_q <= all_finished;
			case (cmd.emit_sel)
				EMIT_BURST: begin
					target_q       <= cnt_q;
					window_q       <= burst_grant ? scaled : '0;
					window_valid_q <= 1'b1;
					sender_done_q  <= 1'b0;
					last_q         <= burst_last;
				end
				EMIT_DONE: begin
					target_q       <= idx_q;
					window_q       <= '0;
					window_valid_q <= 1'b1;
					sender_done_q  <= 1'b1;
					last_q         <= !grant_more;
				end
				EMIT_GRANT: begin
					target_q       <= pick_idx;
					window_q       <= scaled;
					window_valid_q <= 1'b1;
					sender_done_q  <= 1'b1;
					last_q         <= grant_last;
				end
				default: begin
					target_q       <= idx_q;
					window_q       <= '0;
					window_valid_q <= 1'b0;
					sender_done_q  <= 1'b0;
					last_q         <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign target_sender = target_q;
	assign window_value  = window_q;
	assign window_valid  = window_valid_q;
	assign sender_done   = sender_done_q;
	assign burst_done    = burst_done_q;
	assign last          = last_q;

	always_comb begin
		status.is_burst   = (kind_q == KIND_BURST);
		status.in_range   = {1'b0, idx_q} < n_act;
		status.upd_done   = upd_done;
		status.burst_last = burst_last;
		status.scan_last  = (cnt_q == SENDER_W'(NUM_SENDERS - 1));
		status.grant_more = grant_more;
		status.grant_last = grant_last;
		status.out_free   = out_free;
	end

endmodule
